// File: rtl/mhpq_pkg.sv
package mhpq_pkg;

   // Store geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CHILD_W  = IDX_W + 1;

   // Field widths
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int PRIO_W     = 16;
   localparam int PAY_W      = 32;
   localparam int OUT_CNT_W  = 7;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_APPEND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BUILD   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXTRACT = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic signed [PRIO_W-1:0] prio;
      logic [PAY_W-1:0]         pay;
   } entry_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;          // capture request, clear working result
      logic append;         // store request entry at the end
      logic build_init;     // start parent index at count / 2
      logic build_next;     // step to previous parent and read it
      logic load_cur;       // take read data as the sifting entry
      logic ext_read;       // read root and last entry
      logic ext_take;       // capture root, move last into hole 0
      logic set_empty;      // flag extract from empty heap
      logic read_children;  // read both children of the hole
      logic place;          // write sifting entry into the hole
      logic descend;        // move larger child up, follow it down
      logic load_rsp;       // load the response register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              count_zero;
      logic              bidx_zero;
      logic              has_left;
      logic              child_gt;
   } status_type;

endpackage

// File: rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue holding up to 64 entries, each a signed 16-bit
// priority and a 32-bit payload. Every request returns exactly one response.
// An append (tuser kind 0) stores the entry at the end without reordering;
// append to a full store reports status 1. A build (kind 1) heapifies the
// stored entries by sifting every parent down, from the last parent back to
// the root. An extract (kind 2) returns the root, moves the last entry into
// the root and sifts it down; extract from an empty heap reports status 2.
// Kind 3 leaves the store unchanged and reports status 0. The sift loop runs
// over the entry RAM (two registered read ports, one write port) and handles
// each level by reading both children, then comparing and moving the larger
// child up.
// One request is processed at a time; a new request is taken while the
// previous response still waits in the output register.
module max_heap_priority_queue (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] priority_req, [47:16] payload
   input  logic [mhpq_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [1:0] kind
   input  logic [mhpq_pkg::KIND_W-1:0]        req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] out_priority, [47:16] out_payload, [54:48] count_after, [55] zero
   output logic [mhpq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // [1:0] status
   output logic [mhpq_pkg::STATUS_W-1:0]      rsp_tuser
);
   import mhpq_pkg::*;

   cmd_type              cmd;
   status_type           stat;
   entry_type            req_entry;
   entry_type            rsp_entry;
   logic [OUT_CNT_W-1:0] rsp_count;

   // Unpack the request
   assign req_entry.prio = req_tdata[PRIO_W-1:0];
   assign req_entry.pay  = req_tdata[PRIO_W+PAY_W-1:PRIO_W];

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mhpq_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_kind   (req_tuser),
      .req_entry  (req_entry),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_status (rsp_tuser),
      .rsp_entry  (rsp_entry),
      .rsp_count  (rsp_count)
   );

   // Pack the response
   assign rsp_tdata = {1'b0, rsp_count, rsp_entry.pay, rsp_entry.prio};

endmodule

// File: rtl/mhpq_ctrl.sv
module mhpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  mhpq_pkg::status_type   stat,
   output mhpq_pkg::cmd_type      cmd
);
   import mhpq_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_EXT    = 4'd2;
   localparam logic [3:0] S_BCHK   = 4'd3;
   localparam logic [3:0] S_BLOAD  = 4'd4;
   localparam logic [3:0] S_SREAD  = 4'd5;
   localparam logic [3:0] S_SCMP   = 4'd6;
   localparam logic [3:0] S_RESP   = 4'd7;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;
   logic [3:0] sift_done;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // Where a finished sift returns to
   assign sift_done  = (stat.kind == KIND_BUILD) ? S_BCHK : S_RESP;

   // Sequence one request through the datapath
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.kind)
               KIND_APPEND: begin
                  cmd.append = 1'b1;
                  state_in   = S_RESP;
               end
               KIND_BUILD: begin
                  cmd.build_init = 1'b1;
                  state_in       = S_BCHK;
               end
               KIND_EXTRACT: begin
                  if (stat.count_zero) begin
                     cmd.set_empty = 1'b1;
                     state_in      = S_RESP;
                  end else begin
                     cmd.ext_read = 1'b1;
                     state_in     = S_EXT;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_EXT: begin
            cmd.ext_take = 1'b1;
            state_in     = S_SREAD;
         end
         S_BCHK: begin
            if (stat.bidx_zero) begin
               state_in = S_RESP;
            end else begin
               cmd.build_next = 1'b1;
               state_in       = S_BLOAD;
            end
         end
         S_BLOAD: begin
            cmd.load_cur = 1'b1;
            state_in     = S_SREAD;
         end
         S_SREAD: begin
            if (stat.has_left) begin
               cmd.read_children = 1'b1;
               state_in          = S_SCMP;
            end else begin
               cmd.place = 1'b1;
               state_in  = sift_done;
            end
         end
         S_SCMP: begin
            if (stat.child_gt) begin
               cmd.descend = 1'b1;
               state_in    = S_SREAD;
            end else begin
               cmd.place = 1'b1;
               state_in  = sift_done;
            end
         end
         S_RESP: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the response until taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/mhpq_datapath.sv
module mhpq_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [mhpq_pkg::KIND_W-1:0]      req_kind,
   input  mhpq_pkg::entry_type              req_entry,
   input  mhpq_pkg::cmd_type                cmd,
   output mhpq_pkg::status_type             stat,
   output logic [mhpq_pkg::STATUS_W-1:0]    rsp_status,
   output mhpq_pkg::entry_type              rsp_entry,
   output logic [mhpq_pkg::OUT_CNT_W-1:0]   rsp_count
);
   import mhpq_pkg::*;

   entry_type mem [CAPACITY];

   logic [KIND_W-1:0]   kind_ff;
   entry_type           req_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    bidx_ff, bidx_in;
   logic [IDX_W-1:0]    hole_ff, hole_in;
   entry_type           cur_ff, cur_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   entry_type           res_entry_ff, res_entry_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   entry_type           rsp_entry_ff;
   logic [OUT_CNT_W-1:0] rsp_count_ff;

   entry_type           rdata_a_ff, rdata_b_ff;
   logic                rd_en_a, rd_en_b;
   logic [IDX_W-1:0]    rd_addr_a, rd_addr_b;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;

   logic                full;
   logic [CHILD_W-1:0]  left_w, right_w, count_w;
   logic                right_ok, pick_right;
   entry_type           child;
   logic [IDX_W-1:0]    child_idx;

   // Child positions of the hole
   assign count_w    = CHILD_W'(count_ff);
   assign left_w     = {hole_ff, 1'b1};
   assign right_w    = left_w + CHILD_W'(1);
   assign right_ok   = right_w < count_w;
   assign pick_right = right_ok &&
                       ($signed(rdata_a_ff.prio) < $signed(rdata_b_ff.prio));
   assign child      = pick_right ? rdata_b_ff : rdata_a_ff;
   assign child_idx  = pick_right ? IDX_W'(right_w) : IDX_W'(left_w);
   assign full       = count_ff >= CNT_W'(CAPACITY);

   assign stat.kind       = kind_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.bidx_zero  = (bidx_ff == '0);
   assign stat.has_left   = left_w < count_w;
   assign stat.child_gt   = $signed(cur_ff.prio) < $signed(child.prio);

   // Select memory ports
   always_comb begin
      rd_en_a   = cmd.ext_read || cmd.build_next || cmd.read_children;
      rd_en_b   = cmd.ext_read || cmd.read_children;
      rd_addr_a = '0;
      rd_addr_b = IDX_W'(right_w);
      if (cmd.build_next) begin
         rd_addr_a = bidx_ff - IDX_W'(1);
      end else if (cmd.read_children) begin
         rd_addr_a = IDX_W'(left_w);
      end
      if (cmd.ext_read) begin
         rd_addr_b = IDX_W'(count_ff - CNT_W'(1));
      end
      wr_en   = (cmd.append && !full) || cmd.place || cmd.descend;
      wr_addr = cmd.append ? IDX_W'(count_ff) : hole_ff;
      wr_data = cmd.append ? req_ff : (cmd.descend ? child : cur_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en_a) begin
         rdata_a_ff <= mem[rd_addr_a];
      end
      if (rd_en_b) begin
         rdata_b_ff <= mem[rd_addr_b];
      end
   end

   // Update count, indexes and working result
   always_comb begin
      count_in      = count_ff;
      bidx_in       = bidx_ff;
      hole_in       = hole_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      if (cmd.latch) begin
         res_status_in = STATUS_OK;
         res_entry_in  = '0;
      end
      if (cmd.append) begin
         if (full) begin
            res_status_in = STATUS_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.set_empty) begin
         res_status_in = STATUS_EMPTY;
      end
      if (cmd.build_init) begin
         bidx_in = IDX_W'(count_ff >> 1);
      end
      if (cmd.build_next) begin
         bidx_in = bidx_ff - IDX_W'(1);
         hole_in = bidx_ff - IDX_W'(1);
      end
      if (cmd.load_cur) begin
         cur_in = rdata_a_ff;
      end
      if (cmd.ext_take) begin
         res_entry_in = rdata_a_ff;
         cur_in       = rdata_b_ff;
         count_in     = count_ff - CNT_W'(1);
         hole_in      = '0;
      end
      if (cmd.descend) begin
         hole_in = child_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         kind_ff <= req_kind;
         req_ff  <= req_entry;
      end
      bidx_ff       <= bidx_in;
      hole_ff       <= hole_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_entry_ff  <= res_entry_ff;
         rsp_count_ff  <= OUT_CNT_W'(count_ff);
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_count  = rsp_count_ff;

   // Append into free room grows the count by one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.append && !full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow count");

   // Extract shrinks the count by one
   assert property (@(posedge clock) disable iff (reset)
      cmd.ext_take |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("extract did not shrink count");

   // Sift moves strictly deeper and stays inside the heap
   assert property (@(posedge clock) disable iff (reset)
      cmd.descend |=> ((hole_ff > $past(hole_ff)) && (CHILD_W'(hole_ff) < count_w)))
      else $error("sift step left the heap");

   // Count never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (count_ff <= CNT_W'(CAPACITY)))
      else $error("count beyond capacity");

endmodule
